// ----- src/csma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csma_pkg: shared types and constants
// Phase codes, register indexes, reset values and controller/datapath bundles.
// ----------------------------------------------------------------------------
package csma_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int CFG_W           = 16;
	localparam int IDX_W           = 3;
	localparam int RND_W           = 32;
	localparam logic [3:0] MAX_EXP   = 4'd10;
	localparam logic [3:0] RETRY_MAX = 4'd15;

	localparam logic [7:0]  DIFS_RST = 8'd2;
	localparam logic [7:0]  SIFS_RST = 8'd1;
	localparam logic [7:0]  RTS_RST  = 8'd2;
	localparam logic [7:0]  CTS_RST  = 8'd2;
	localparam logic [7:0]  ACK_RST  = 8'd2;
	localparam logic [11:0] DATA_RST = 12'd100;
	localparam logic [7:0]  CWMIN_RST = 8'd4;
	localparam logic [15:0] CWMAX_RST = 16'd1024;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_DIFS     = 4'd1,
		PH_BACKOFF  = 4'd2,
		PH_FREEZE   = 4'd3,
		PH_RTS      = 4'd4,
		PH_RTS_SIFS = 4'd5,
		PH_CTS      = 4'd6,
		PH_CTS_SIFS = 4'd7,
		PH_DATA     = 4'd8,
		PH_SIFS     = 4'd9,
		PH_ACK      = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		REG_DIFS  = 3'd0,
		REG_SIFS  = 3'd1,
		REG_RTS   = 3'd2,
		REG_CTS   = 3'd3,
		REG_ACK   = 3'd4,
		REG_DATA  = 3'd5,
		REG_CWMIN = 3'd6,
		REG_CWMAX = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic draw_pending;
		logic step_done;
		logic step_draw;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/csma_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csma_dp: sender datapath
// Registers, phase counters, statistics, one-phase step logic and a
// bit-serial remainder unit for backoff draws.
// ----------------------------------------------------------------------------
module csma_dp #(
	parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_DEF,
	localparam int PEND_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [csma_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [csma_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       frame_arrival,
	input  wire logic                       channel_busy,
	input  wire logic                       collision_report,
	input  wire logic [csma_pkg::RND_W-1:0] random_value,
	input  wire csma_pkg::cmd_t             cmd,
	output csma_pkg::sts_t                  sts,
	output logic [3:0]                      phase,
	output logic [31:0]                     ack_total,
	output logic [31:0]                     collision_total,
	output logic [PEND_W-1:0]               frames_pending
);

	// configuration
	logic [7:0]  difs_cfg_q, sifs_cfg_q, rts_cfg_q, cts_cfg_q, ack_cfg_q, cwmin_q;
	logic [11:0] data_cfg_q;
	logic [15:0] cwmax_q;

	// sender state
	csma_pkg::phase_t mode_q, n_mode;
	logic [PEND_W-1:0] pend_q, n_pend;
	logic [7:0]  difs_q, sifs_q, rts_q, cts_q, ack_q;
	logic [7:0]  n_difs, n_sifs, n_rts, n_cts, n_ack;
	logic [11:0] data_q, n_data;
	logic [15:0] backoff_q, n_backoff;
	logic        draw_pend_q, mark_q, n_mark;
	logic [3:0]  retry_q, n_retry;
	logic [31:0] acks_q, cols_q, n_acks, n_cols;
	logic        busy_q;
	logic [31:0] rnd_q;

	// remainder unit
	logic        div_busy_q;
	logic [4:0]  div_cnt_q;
	logic [15:0] div_rem_q, div_d_q;
	logic [31:0] div_num_q;
	logic [16:0] trial;
	logic        trial_ge;
	logic [15:0] rem_next;

	// step results
	logic        step_done, step_draw;
	logic [15:0] draw_div;

	logic [15:0] short_div;
	logic [3:0]  col_k;
	logic [17:0] col_w;
	logic [3:0]  retry_inc;

	// output register
	logic [3:0]        phase_q;
	logic [31:0]       acks_out_q, cols_out_q;
	logic [PEND_W-1:0] pend_out_q;

	assign short_div = {8'd0, cwmin_q - {7'd0, (cwmin_q != 8'd0)}};
	assign retry_inc = (retry_q < csma_pkg::RETRY_MAX) ? retry_q + 4'd1 : retry_q;
	assign col_k     = (retry_inc < csma_pkg::MAX_EXP) ? retry_inc : csma_pkg::MAX_EXP;

	always_comb begin
		col_w = ({10'd0, cwmin_q} << col_k) - 18'd1;
		if (cwmin_q == 8'd0)
			col_w = '0;
		if (col_w > {2'd0, cwmax_q})
			col_w = {2'd0, cwmax_q};
	end

	always_comb begin
		n_mode = mode_q;  n_pend = pend_q;
		n_difs = difs_q;  n_sifs = sifs_q;  n_rts = rts_q;
		n_cts = cts_q;    n_ack = ack_q;    n_data = data_q;
		n_backoff = backoff_q;
		n_mark = mark_q;  n_retry = retry_q;
		n_acks = acks_q;  n_cols = cols_q;
		step_done = 1'b0; step_draw = 1'b0;
		draw_div = short_div;
		unique case (mode_q)
			csma_pkg::PH_IDLE: begin
				if (pend_q != '0) n_mode = csma_pkg::PH_DIFS;
				else step_done = 1'b1;
			end
			csma_pkg::PH_DIFS: begin
				if (difs_q != 8'd0) begin
					n_difs = difs_q - 8'd1; step_done = 1'b1;
				end else n_mode = csma_pkg::PH_BACKOFF;
			end
			csma_pkg::PH_BACKOFF: begin
				if (busy_q) n_mode = csma_pkg::PH_FREEZE;
				else if (backoff_q != 16'd0) begin
					n_backoff = backoff_q - 16'd1; step_done = 1'b1;
				end else n_mode = csma_pkg::PH_RTS;
			end
			csma_pkg::PH_FREEZE: begin
				if (busy_q) step_done = 1'b1;
				else n_mode = csma_pkg::PH_BACKOFF;
			end
			csma_pkg::PH_RTS: begin
				if (rts_q != 8'd0) begin
					n_rts = rts_q - 8'd1; step_done = 1'b1;
				end else begin
					n_sifs = sifs_cfg_q; n_mode = csma_pkg::PH_RTS_SIFS;
				end
			end
			csma_pkg::PH_RTS_SIFS: begin
				if (sifs_q != 8'd0) begin
					n_sifs = sifs_q - 8'd1; step_done = 1'b1;
				end else n_mode = csma_pkg::PH_CTS;
			end
			csma_pkg::PH_CTS: begin
				if (cts_q != 8'd0) begin
					n_cts = cts_q - 8'd1; step_done = 1'b1;
				end else begin
					n_sifs = sifs_cfg_q; n_mode = csma_pkg::PH_CTS_SIFS;
				end
			end
			csma_pkg::PH_CTS_SIFS: begin
				if (sifs_q != 8'd0) begin
					n_sifs = sifs_q - 8'd1; step_done = 1'b1;
				end else if (mark_q) begin
					n_cols = cols_q + 32'd1;
					n_retry = retry_inc;
					n_difs = difs_cfg_q; n_sifs = sifs_cfg_q; n_rts = rts_cfg_q;
					n_cts = cts_cfg_q;   n_ack = ack_cfg_q;   n_data = data_cfg_q;
					step_draw = 1'b1;
					draw_div = col_w[15:0];
					n_mark = 1'b0;
					n_mode = csma_pkg::PH_IDLE;
				end else begin
					n_data = data_cfg_q; n_sifs = sifs_cfg_q;
					n_mode = csma_pkg::PH_DATA;
				end
			end
			csma_pkg::PH_DATA: begin
				if (data_q != 12'd0) begin
					n_data = data_q - 12'd1; step_done = 1'b1;
				end else n_mode = csma_pkg::PH_SIFS;
			end
			csma_pkg::PH_SIFS: begin
				if (sifs_q != 8'd0) begin
					n_sifs = sifs_q - 8'd1; step_done = 1'b1;
				end else n_mode = csma_pkg::PH_ACK;
			end
			csma_pkg::PH_ACK: begin
				if (ack_q != 8'd0) begin
					n_ack = ack_q - 8'd1; step_done = 1'b1;
				end else begin
					if (pend_q != '0) n_pend = pend_q - PEND_W'(1);
					n_difs = difs_cfg_q; n_sifs = sifs_cfg_q; n_rts = rts_cfg_q;
					n_cts = cts_cfg_q;   n_ack = ack_cfg_q;   n_data = data_cfg_q;
					step_draw = 1'b1;
					n_retry = 4'd0;
					n_acks = acks_q + 32'd1;
					n_mode = csma_pkg::PH_IDLE;
				end
			end
			default: n_mode = csma_pkg::PH_IDLE;
		endcase
	end

	assign trial    = {div_rem_q, div_num_q[31]};
	assign trial_ge = trial >= {1'b0, div_d_q};
	assign rem_next = trial_ge ? 16'(trial - {1'b0, div_d_q}) : trial[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			difs_cfg_q <= csma_pkg::DIFS_RST;  sifs_cfg_q <= csma_pkg::SIFS_RST;
			rts_cfg_q  <= csma_pkg::RTS_RST;   cts_cfg_q  <= csma_pkg::CTS_RST;
			ack_cfg_q  <= csma_pkg::ACK_RST;   data_cfg_q <= csma_pkg::DATA_RST;
			cwmin_q    <= csma_pkg::CWMIN_RST; cwmax_q    <= csma_pkg::CWMAX_RST;
			mode_q <= csma_pkg::PH_IDLE;
			pend_q <= '0;
			difs_q <= csma_pkg::DIFS_RST; sifs_q <= csma_pkg::SIFS_RST;
			rts_q  <= csma_pkg::RTS_RST;  cts_q  <= csma_pkg::CTS_RST;
			ack_q  <= csma_pkg::ACK_RST;  data_q <= csma_pkg::DATA_RST;
			backoff_q <= '0;
			draw_pend_q <= 1'b1;
			retry_q <= '0;
			mark_q <= 1'b0;
			acks_q <= '0;
			cols_q <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (csma_pkg::reg_idx_t'(cfg_index))
					csma_pkg::REG_DIFS:  difs_cfg_q <= cfg_data[7:0];
					csma_pkg::REG_SIFS:  sifs_cfg_q <= cfg_data[7:0];
					csma_pkg::REG_RTS:   rts_cfg_q  <= cfg_data[7:0];
					csma_pkg::REG_CTS:   cts_cfg_q  <= cfg_data[7:0];
					csma_pkg::REG_ACK:   ack_cfg_q  <= cfg_data[7:0];
					csma_pkg::REG_DATA:  data_cfg_q <= cfg_data[11:0];
					csma_pkg::REG_CWMIN: cwmin_q    <= cfg_data[7:0];
					csma_pkg::REG_CWMAX: cwmax_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (frame_arrival && pend_q < PEND_W'(QUEUE_DEPTH))
					pend_q <= pend_q + PEND_W'(1);
				if (collision_report)
					mark_q <= 1'b1;
				if (draw_pend_q) begin
					draw_pend_q <= 1'b0;
					div_busy_q  <= 1'b1;
					div_cnt_q   <= 5'd31;
				end
			end
			if (cmd.step) begin
				mode_q <= n_mode; pend_q <= n_pend;
				difs_q <= n_difs; sifs_q <= n_sifs; rts_q <= n_rts;
				cts_q <= n_cts;   ack_q <= n_ack;   data_q <= n_data;
				backoff_q <= n_backoff;
				mark_q <= n_mark; retry_q <= n_retry;
				acks_q <= n_acks; cols_q <= n_cols;
				if (step_draw) begin
					div_busy_q <= 1'b1;
					div_cnt_q  <= 5'd31;
				end
			end
			if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - 5'd1;
				if (div_cnt_q == 5'd0) begin
					div_busy_q <= 1'b0;
					backoff_q  <= (div_d_q == 16'd0) ? 16'd0 : rem_next;
				end
			end
		end
	end

	// payload: tick inputs, remainder working regs, result beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			busy_q <= channel_busy;
			rnd_q  <= random_value;
			div_num_q <= random_value;
			div_rem_q <= '0;
			div_d_q   <= short_div;
		end else if (cmd.step && step_draw) begin
			div_num_q <= rnd_q;
			div_rem_q <= '0;
			div_d_q   <= draw_div;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[30:0], 1'b0};
			div_rem_q <= rem_next;
		end
		if (cmd.load_out) begin
			phase_q    <= mode_q;
			acks_out_q <= acks_q;
			cols_out_q <= cols_q;
			pend_out_q <= pend_q;
		end
	end

	assign sts.draw_pending = draw_pend_q;
	assign sts.step_done    = step_done;
	assign sts.step_draw    = step_draw;
	assign sts.div_done     = div_busy_q && (div_cnt_q == 5'd0);

	assign phase           = phase_q;
	assign ack_total       = acks_out_q;
	assign collision_total = cols_out_q;
	assign frames_pending  = pend_out_q;

endmodule
`default_nettype wire

// ----- src/csma_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csma_ctrl: tick sequencer
// Accepts a tick, waits out backoff draws, walks phases one per cycle between
// draws and hands the result to the output register.
// ----------------------------------------------------------------------------
module csma_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire csma_pkg::sts_t sts,
	output csma_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_WALK = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n = sts.draw_pending ? S_DIV : S_WALK;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_n = S_WALK;
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.step_draw) state_n = S_DIV;
				else if (sts.step_done) begin
					if (out_free) begin
						cmd.load_out = 1'b1;
						state_n = S_IDLE;
					end else state_n = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- src/csma_ca_rts_cts_transmitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csma_ca_rts_cts_transmitter: slot-timed CSMA/CA sender with RTS/CTS
// Top level joining the tick sequencer and the sender datapath.
// ----------------------------------------------------------------------------
// Each input beat is one slot tick and yields one result beat. A tick is
// accepted, then walks the phases it visits and waits out each backoff draw,
// which runs through a bit-serial remainder unit (the first tick after reset,
// each ack and each collision draw once). A new tick is taken while the
// previous result beat still waits at the output.
// ----------------------------------------------------------------------------
module csma_ca_rts_cts_transmitter #(
	parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_DEF,
	localparam int PEND_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [csma_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [csma_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       frame_arrival,
	input  wire logic                       channel_busy,
	input  wire logic                       collision_report,
	input  wire logic [csma_pkg::RND_W-1:0] random_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [3:0]                      phase,
	output logic [31:0]                     ack_total,
	output logic [31:0]                     collision_total,
	output logic [PEND_W-1:0]               frames_pending
);

	csma_pkg::cmd_t cmd;
	csma_pkg::sts_t sts;

	csma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csma_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.frame_arrival    (frame_arrival),
		.channel_busy     (channel_busy),
		.collision_report (collision_report),
		.random_value     (random_value),
		.cmd              (cmd),
		.sts              (sts),
		.phase            (phase),
		.ack_total        (ack_total),
		.collision_total  (collision_total),
		.frames_pending   (frames_pending)
	);

	// walk never steps while a draw is finishing
	a_no_step_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && sts.div_done))
		else $error("phase step during backoff draw");

	// result beat only loaded into a free output slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result beat overwritten");

	// after a tick is taken the next result appears before another tick
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("tick accepted without processing");

endmodule
`default_nettype wire
